// ----- hdl/fic_pkg.sv -----
package fic_pkg;

    // Default number of view slots in the table.
    localparam int FIC_VIEWS = 16;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 4;
    localparam int REV_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 200;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_INVALIDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUMP       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRESENT    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DESTROY    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MERGED   = 2'd3;

    // One pending invalidation record; the document revision sits lowest.
    typedef struct packed {
        logic [REV_W-1:0] reasons;
        logic [REV_W-1:0] generation;
        logic [REV_W-1:0] preview_rev;
        logic [REV_W-1:0] view_rev;
        logic [REV_W-1:0] document_rev;
    } fic_rec_t;

    localparam int REC_W = $bits(fic_rec_t);

    // Unsigned maximum of two revisions.
    function automatic logic [REV_W-1:0] rev_max(input logic [REV_W-1:0] a,
                                                 input logic [REV_W-1:0] b);
        rev_max = (a > b) ? a : b;
    endfunction

endpackage

// ----- hdl/fic_ram.sv -----
module fic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/frame_invalidation_coalescer_top.sv -----
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+---------------------------------------
// s_ (cmd)  | in  | s_tvalid/s_tready  | s_tuser command, s_tdata slot + record
// m_ (res)  | out | m_tvalid/m_tready  | m_tuser status, m_tdata record + state
//
// Each word is handled in order: the slot's entries are read from the table
// memories, then they are updated and the result register is loaded.
// The read comes first because each memory has a single registered read port.
// A new word is taken while the previous result still waits on m_tready;
// the update then stalls until the result register is free.
// Reset clears the valid bits and the pending count; the memories need no
// clearing pass, as an entry without its valid bit reads as empty or zero.
module frame_invalidation_coalescer_top #(
    parameter int VIEWS = fic_pkg::FIC_VIEWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // view_slot, document_revision, view_revision, preview_revision,
    // frame_generation, match generation, reason bits, zero padding.
    input  logic [fic_pkg::IN_DATA_W-1:0]   s_tdata,
    // command.
    input  logic [fic_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_document_revision, out_view_revision, out_preview_revision,
    // out_generation, pumped reason bits, presented_revision, pending_count,
    // zero padding.
    output logic [fic_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status.
    output logic [fic_pkg::STATUS_W-1:0]    m_tuser
);

    import fic_pkg::*;

    // Only sixteen slots can be addressed by the slot field.
    localparam int SLOTS = (VIEWS < 16) ? VIEWS : 16;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W:0] SLOTS_W = (SLOT_W + 1)'(SLOTS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic               state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [SLOT_W-1:0]  slot_reg;
    fic_rec_t           in_rec_reg;
    logic [REV_W-1:0]   tgen_reg;

    logic [SLOTS-1:0]   pend_valid_reg, pend_valid_next;
    logic [SLOTS-1:0]   pres_valid_reg, pres_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [STATUS_W-1:0]   m_user_reg;

    logic             accept;
    logic             exec_fire;
    logic [AW-1:0]    addr;
    logic             in_range;
    logic             pv;
    logic [REV_W-1:0] cur_pres;

    fic_rec_t         pend_rdata, pend_wdata, rec_out;
    logic             pend_we;
    logic [REV_W-1:0] pres_rdata, pres_wdata, pres_out;
    logic             pres_we;
    logic [STATUS_W-1:0] status;

    // Handshakes.
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Pending records and presented revisions live in two memories.
    fic_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_pend_ram (
        .aclk  (aclk),
        .we    (pend_we),
        .waddr (addr),
        .wdata (pend_wdata),
        .re    (accept),
        .raddr (s_tdata[AW-1:0]),
        .rdata (pend_rdata)
    );

    fic_ram #(.WIDTH(REV_W), .DEPTH(SLOTS)) u_pres_ram (
        .aclk  (aclk),
        .we    (pres_we),
        .waddr (addr),
        .wdata (pres_wdata),
        .re    (accept),
        .raddr (s_tdata[AW-1:0]),
        .rdata (pres_rdata)
    );

    assign addr     = slot_reg[AW-1:0];
    assign in_range = ({1'b0, slot_reg} < SLOTS_W);
    assign pv       = pend_valid_reg[addr];
    assign cur_pres = pres_valid_reg[addr] ? pres_rdata : '0;

    // Update of the addressed slot from the memory read data.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pres_valid_next = pres_valid_reg;
        count_next      = count_reg;
        pend_we         = 1'b0;
        pres_we         = 1'b0;
        pend_wdata      = in_rec_reg;
        pres_wdata      = rev_max(cur_pres, in_rec_reg.document_rev);
        rec_out         = '0;
        pres_out        = '0;
        status          = STAT_NONE;
        if (in_range) begin
            pres_out = cur_pres;
            unique case (cmd_reg)
                CMD_INVALIDATE: begin
                    pend_we = 1'b1;
                    if (!pv) begin
                        pend_valid_next[addr] = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                        status     = STAT_OK;
                    end else begin
                        pend_wdata.document_rev = rev_max(pend_rdata.document_rev,
                                                          in_rec_reg.document_rev);
                        pend_wdata.view_rev     = rev_max(pend_rdata.view_rev,
                                                          in_rec_reg.view_rev);
                        pend_wdata.preview_rev  = rev_max(pend_rdata.preview_rev,
                                                          in_rec_reg.preview_rev);
                        pend_wdata.generation   = rev_max(pend_rdata.generation,
                                                          in_rec_reg.generation);
                        pend_wdata.reasons      = pend_rdata.reasons | in_rec_reg.reasons;
                        status = STAT_MERGED;
                    end
                end
                CMD_PUMP: begin
                    if (!pv) begin
                        status = STAT_NONE;
                    end else if (pend_rdata.generation != tgen_reg) begin
                        status = STAT_MISMATCH;
                    end else begin
                        rec_out = pend_rdata;
                        pend_valid_next[addr] = 1'b0;
                        count_next = count_reg - COUNT_W'(1);
                        status     = STAT_OK;
                    end
                end
                CMD_PRESENT: begin
                    if (in_rec_reg.generation != tgen_reg) begin
                        status = STAT_MISMATCH;
                    end else begin
                        pres_we  = 1'b1;
                        pres_valid_next[addr] = 1'b1;
                        pres_out = pres_wdata;
                        status   = STAT_OK;
                    end
                end
                CMD_DESTROY: begin
                    if (pv) begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                    pend_valid_next[addr] = 1'b0;
                    pres_valid_next[addr] = 1'b0;
                    pres_out = '0;
                    status   = STAT_OK;
                end
                default: begin
                    status = STAT_NONE;
                end
            endcase
        end
        if (!exec_fire) begin
            pend_we = 1'b0;
            pres_we = 1'b0;
        end
    end

    // Sequencer: read on accept, update once the result register is free.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= '0;
            pres_valid_reg <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                pend_valid_reg <= pend_valid_next;
                pres_valid_reg <= pres_valid_next;
                count_reg      <= count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Captured input word and the result register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg                 <= s_tuser;
            slot_reg                <= s_tdata[3:0];
            in_rec_reg.document_rev <= s_tdata[35:4];
            in_rec_reg.view_rev     <= s_tdata[67:36];
            in_rec_reg.preview_rev  <= s_tdata[99:68];
            in_rec_reg.generation   <= s_tdata[131:100];
            tgen_reg                <= s_tdata[163:132];
            in_rec_reg.reasons      <= s_tdata[195:164];
        end
        if (exec_fire) begin
            m_data_reg <= {3'b000, count_next, pres_out, rec_out};
            m_user_reg <= status;
        end
    end

endmodule
